// ----- rtl/ttwm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the task to worker mapper.
// No dependencies; imported by every module of the block.
package ttwm_pkg;

   localparam int TASK_BITS_DEF  = 16;
   localparam int MAX_NODES_DEF  = 256;
   localparam int WORKER_BITS    = 8;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_TASKS     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NODE_COUNT      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONTIGUOUS_MODE = 2'd2;

endpackage

// ----- rtl/ttwm_div_cell.sv -----
`timescale 1ns / 1ps
// One restoring division step with its own pipeline register and handshake.
// Depends on ttwm_pkg; instantiated by ttwm_div_chain.
module ttwm_div_cell #(
   parameter int NW = ttwm_pkg::TASK_BITS_DEF,
   parameter int DW = ttwm_pkg::TASK_BITS_DEF,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [DW-1:0] in_rem,
   input  logic [NW-1:0] in_nq,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [DW-1:0] out_rem,
   output logic [NW-1:0] out_nq,
   output logic [DW-1:0] out_den,
   output logic [SW-1:0] out_side
);
   import ttwm_pkg::*;

   logic          valid_ff;
   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [NW-1:0] nq_ff, nq_in;
   logic [SW-1:0] side_ff;
   logic [DW:0]   trial;
   logic          ge;

   always_comb begin
      trial  = {in_rem, in_nq[NW-1]};
      ge     = trial >= {1'b0, in_den};
      rem_in = ge ? DW'(trial - {1'b0, in_den}) : trial[DW-1:0];
      nq_in  = {in_nq[NW-2:0], ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

// ----- rtl/ttwm_div_chain.sv -----
`timescale 1ns / 1ps
// Pipelined divider: a row of NW division cells, one quotient bit per cell.
// Depends on ttwm_pkg and ttwm_div_cell.
module ttwm_div_chain #(
   parameter int NW = ttwm_pkg::TASK_BITS_DEF,
   parameter int DW = ttwm_pkg::TASK_BITS_DEF,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [NW-1:0] out_quo,
   output logic [DW-1:0] out_rem,
   output logic [DW-1:0] out_den,
   output logic [SW-1:0] out_side
);
   import ttwm_pkg::*;

   logic          vld  [0:NW];
   logic          rdy  [0:NW];
   logic [DW-1:0] rem  [0:NW];
   logic [NW-1:0] nq   [0:NW];
   logic [DW-1:0] den  [0:NW];
   logic [SW-1:0] side [0:NW];

   assign vld[0]   = in_valid;
   assign in_ready = rdy[0];
   assign rem[0]   = '0;
   assign nq[0]    = in_num;
   assign den[0]   = in_den;
   assign side[0]  = in_side;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      ttwm_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[i]),
         .in_ready  (rdy[i]),
         .in_rem    (rem[i]),
         .in_nq     (nq[i]),
         .in_den    (den[i]),
         .in_side   (side[i]),
         .out_valid (vld[i+1]),
         .out_ready (rdy[i+1]),
         .out_rem   (rem[i+1]),
         .out_nq    (nq[i+1]),
         .out_den   (den[i+1]),
         .out_side  (side[i+1])
      );
   end

   assign rdy[NW]   = out_ready;
   assign out_valid = vld[NW];
   assign out_quo   = nq[NW];
   assign out_rem   = rem[NW];
   assign out_den   = den[NW];
   assign out_side  = side[NW];

endmodule

// ----- rtl/task_to_worker_mapper_unit.sv -----
`timescale 1ns / 1ps
// Task to worker mapper, top level: registers, two divider chains, output stage.
// Depends on ttwm_pkg and ttwm_div_chain.
//
// Usage: req_ carries one task index per transaction; rsp_ returns one
// transaction per task with worker number, local index and worker task count
// in rsp_tdata and the invalid flag in rsp_tuser. csr_ writes total_tasks
// (index 0), node_count (1) and contiguous_mode (2); it is always ready and
// must only be written while the block is empty.
// The pipeline is one divider chain of TASK_BITS cells for total / workers, one
// multiply register, a second chain of TASK_BITS cells for the task division,
// and the output register. Throughput is one transaction per cycle while
// rsp_tready is high; every cell holds one transaction.
// When rsp_tready is low the output register holds and the cells behind it
// fill up, bubbles first, before req_tready drops.
// Reset empties the pipeline and sets total_tasks 0, node_count 2, cyclic mode.
module task_to_worker_mapper_unit #(
   parameter int TASK_BITS = ttwm_pkg::TASK_BITS_DEF,
   parameter int MAX_NODES = ttwm_pkg::MAX_NODES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((TASK_BITS+7)/8)*8-1:0]        req_tdata,  // task_index
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // worker_number, local_index, worker_task_count
   output logic [((ttwm_pkg::WORKER_BITS+2*TASK_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                  rsp_tuser,  // invalid
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ttwm_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [((TASK_BITS > $clog2(MAX_NODES+1)) ? TASK_BITS
                  : $clog2(MAX_NODES+1))-1:0]   csr_data
);
   import ttwm_pkg::*;

   localparam int TB   = TASK_BITS;
   localparam int NB   = $clog2(MAX_NODES + 1);
   localparam int WB   = $clog2(MAX_NODES);
   localparam int DW2  = (TB > WB) ? TB : WB;
   localparam int SPW  = TB + WB + 1;
   localparam int SW1  = TB + 2;
   localparam int SW2  = TB + WB + 3;
   localparam int RSPW = ((WORKER_BITS + 2*TB + 7) / 8) * 8;

   // configuration registers
   logic [TB-1:0] total_tasks_ff;
   logic [NB-1:0] node_count_ff;
   logic          contiguous_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_tasks_ff     <= '0;
         node_count_ff      <= NB'(2);
         contiguous_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOTAL_TASKS:     total_tasks_ff     <= csr_data[TB-1:0];
            CSR_NODE_COUNT:      node_count_ff      <= csr_data[NB-1:0];
            CSR_CONTIGUOUS_MODE: contiguous_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // worker count and range check
   logic [TB-1:0] task_idx;
   logic [NB-1:0] nodes_clamp;
   logic [WB-1:0] avail, workers;
   logic          inv_req;

   always_comb begin
      task_idx    = req_tdata[TB-1:0];
      nodes_clamp = (node_count_ff > NB'(MAX_NODES)) ? NB'(MAX_NODES) : node_count_ff;
      avail       = (nodes_clamp >= NB'(2)) ? WB'(nodes_clamp - NB'(1)) : '0;
      workers     = (32'(total_tasks_ff) < 32'(avail)) ? WB'(total_tasks_ff) : avail;
      inv_req     = (workers == '0) || (task_idx >= total_tasks_ff);
   end

   // chain one: total / workers
   logic           c1_valid, c1_ready;
   logic [TB-1:0]  c1_quo;
   logic [WB-1:0]  c1_rem, c1_den;
   logic [SW1-1:0] c1_side;

   ttwm_div_chain #(.NW(TB), .DW(WB), .SW(SW1)) u_chain_base (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_num    (total_tasks_ff),
      .in_den    (workers),
      .in_side   ({inv_req, contiguous_mode_ff, task_idx}),
      .out_valid (c1_valid),
      .out_ready (c1_ready),
      .out_quo   (c1_quo),
      .out_rem   (c1_rem),
      .out_den   (c1_den),
      .out_side  (c1_side)
   );

   // span of the workers with one extra task
   logic           m_valid_ff;
   logic [TB-1:0]  m_base_ff, m_task_ff;
   logic [WB-1:0]  m_rem_ff, m_wrk_ff;
   logic           m_mode_ff, m_inv_ff;
   logic [SPW-1:0] m_span_ff, m_span_in;
   logic           c2_in_ready;

   assign c1_ready  = !m_valid_ff || c2_in_ready;
   assign m_span_in = SPW'(c1_rem) * SPW'({1'b0, c1_quo} + (TB+1)'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (c1_ready) begin
         m_valid_ff <= c1_valid;
      end
      if (c1_ready && c1_valid) begin
         m_base_ff <= c1_quo;
         m_rem_ff  <= c1_rem;
         m_wrk_ff  <= c1_den;
         m_task_ff <= c1_side[TB-1:0];
         m_mode_ff <= c1_side[TB];
         m_inv_ff  <= c1_side[TB+1];
         m_span_ff <= m_span_in;
      end
   end

   // chain two operands
   logic           hi;
   logic [TB-1:0]  num2;
   logic [DW2-1:0] den2;

   always_comb begin
      hi = SPW'(m_task_ff) < m_span_ff;
      if (!m_mode_ff) begin
         num2 = m_task_ff;
         den2 = DW2'(m_wrk_ff);
      end else if (hi) begin
         num2 = m_task_ff;
         den2 = DW2'(m_base_ff + TB'(1));
      end else begin
         num2 = m_task_ff - m_span_ff[TB-1:0];
         den2 = DW2'(m_base_ff);
      end
   end

   logic           c2_valid, c2_ready;
   logic [TB-1:0]  c2_quo;
   logic [DW2-1:0] c2_rem, c2_den;
   logic [SW2-1:0] c2_side;

   ttwm_div_chain #(.NW(TB), .DW(DW2), .SW(SW2)) u_chain_place (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid_ff),
      .in_ready  (c2_in_ready),
      .in_num    (num2),
      .in_den    (den2),
      .in_side   ({m_inv_ff, m_mode_ff, hi, m_rem_ff, m_base_ff}),
      .out_valid (c2_valid),
      .out_ready (c2_ready),
      .out_quo   (c2_quo),
      .out_rem   (c2_rem),
      .out_den   (c2_den),
      .out_side  (c2_side)
   );

   // result assembly
   logic [TB-1:0]          f_base;
   logic [WB-1:0]          f_rem;
   logic                   f_hi, f_mode, f_inv;
   logic [DW2:0]           worker;
   logic [WORKER_BITS-1:0] worker_in;
   logic [TB-1:0]          local_in, count_in;
   logic                   extra;

   always_comb begin
      f_base = c2_side[TB-1:0];
      f_rem  = c2_side[TB+WB-1:TB];
      f_hi   = c2_side[TB+WB];
      f_mode = c2_side[TB+WB+1];
      f_inv  = c2_side[TB+WB+2];
      if (!f_mode) begin
         worker = (DW2+1)'(c2_rem);
         extra  = (DW2+1)'(c2_rem) < (DW2+1)'(f_rem);
      end else if (f_hi) begin
         worker = (DW2+1)'(c2_quo);
         extra  = 1'b1;
      end else begin
         worker = (DW2+1)'(f_rem) + (DW2+1)'(c2_quo);
         extra  = 1'b0;
      end
      worker_in = WORKER_BITS'(worker + (DW2+1)'(1));
      local_in  = f_mode ? c2_rem[TB-1:0] : c2_quo;
      count_in  = f_base + TB'(extra);
      if (f_inv) begin
         worker_in = '0;
         local_in  = '0;
         count_in  = '0;
      end
   end

   // output register
   logic                   rsp_valid_ff;
   logic [WORKER_BITS-1:0] rsp_worker_ff;
   logic [TB-1:0]          rsp_local_ff, rsp_count_ff;
   logic                   rsp_inv_ff;

   assign c2_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c2_ready) begin
         rsp_valid_ff <= c2_valid;
      end
      if (c2_ready && c2_valid) begin
         rsp_worker_ff <= worker_in;
         rsp_local_ff  <= local_in;
         rsp_count_ff  <= count_in;
         rsp_inv_ff    <= f_inv;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSPW'({rsp_count_ff, rsp_local_ff, rsp_worker_ff});
   assign rsp_tuser  = rsp_inv_ff;

   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_worker_ff == '0 && rsp_local_ff == '0
                                  && rsp_count_ff == '0)
      else $error("invalid transaction with non-zero fields");

   a_local_below_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_local_ff < rsp_count_ff)
      else $error("local index not below worker task count");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_count_ff != '0)
      else $error("valid transaction with empty worker");

   a_place_divisor: assert property (@(posedge clock) disable iff (reset)
      c2_valid && !f_inv |-> c2_den != '0)
      else $error("placement division by zero");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_count_ff)
                                    && $stable(rsp_local_ff))
      else $error("result changed while stalled");

endmodule

// ----- tb/tb_task_to_worker_mapper_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for task_to_worker_mapper_unit: directed table, a write to an unused index,
// then random phases over several register settings and idling patterns. Depends on ttwm_pkg and the RTL.
module tb_task_to_worker_mapper_unit;
   import ttwm_pkg::*;

   localparam int TB_TASK_BITS = TASK_BITS_DEF;
   localparam int TB_MAX_NODES = MAX_NODES_DEF;
   localparam int REQ_W  = ((TB_TASK_BITS + 7) / 8) * 8;
   localparam int RSP_W  = ((WORKER_BITS + 2 * TB_TASK_BITS + 7) / 8) * 8;
   localparam int CSR_W  = (TB_TASK_BITS > $clog2(TB_MAX_NODES + 1)) ? TB_TASK_BITS
                           : $clog2(TB_MAX_NODES + 1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int PIPE_DEPTH = 2 * TB_TASK_BITS + 2;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [WORKER_BITS-1:0]  worker_number;
      logic [TB_TASK_BITS-1:0] local_index;
      logic [TB_TASK_BITS-1:0] worker_task_count;
      logic                    invalid;
   } placement_type;

   typedef struct {
      logic [CSR_W-1:0]        total_raw;
      logic [CSR_W-1:0]        nodes_raw;
      logic [CSR_W-1:0]        mode_raw;
      logic [TB_TASK_BITS-1:0] task_idx;
      bit                      fixed;
      placement_type           want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   // register shadow
   logic [15:0] cfg_total = 16'd0;
   logic [8:0]  cfg_nodes = 9'd2;
   logic        cfg_contig = 1'b0;

   placement_type    placements_due[$];
   directed_row_type directed_rows[$];
   int               error_count = 0;
   int               send_gap_pct = 0;
   int               recv_stall_pct = 0;
   int               idle_cycles = 0;

   task_to_worker_mapper_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic placement_type place_task(logic [TB_TASK_BITS-1:0] idx);
      int unsigned total, nodes, workers, base, rem, wk, loc, span, rest, t;
      placement_type p;
      p = '0;
      t = 32'(idx);
      total = 32'(cfg_total);
      nodes = 32'(cfg_nodes);
      if (nodes > TB_MAX_NODES) nodes = TB_MAX_NODES;
      workers = (nodes >= 2) ? nodes - 1 : 0;
      if (total < workers) workers = total;
      if (workers == 0 || t >= total) begin
         p.invalid = 1'b1;
         return p;
      end
      base = total / workers;
      rem  = total % workers;
      if (!cfg_contig) begin
         wk  = t % workers;
         loc = t / workers;
      end else begin
         span = rem * (base + 1);
         if (t < span) begin
            wk  = t / (base + 1);
            loc = t % (base + 1);
         end else begin
            rest = t - span;
            wk   = rem + rest / base;
            loc  = rest % base;
         end
      end
      p.worker_number     = WORKER_BITS'(wk + 1);
      p.local_index       = TB_TASK_BITS'(loc);
      p.worker_task_count = TB_TASK_BITS'(base + ((wk < rem) ? 1 : 0));
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic add_row(logic [CSR_W-1:0] total_raw, logic [CSR_W-1:0] nodes_raw,
                          logic [CSR_W-1:0] mode_raw, logic [TB_TASK_BITS-1:0] task_idx,
                          bit fixed, placement_type want);
      directed_row_type r;
      r.total_raw = total_raw;
      r.nodes_raw = nodes_raw;
      r.mode_raw  = mode_raw;
      r.task_idx  = task_idx;
      r.fixed     = fixed;
      r.want      = want;
      directed_rows.push_back(r);
   endtask

   task automatic send_task(logic [TB_TASK_BITS-1:0] idx, bit fixed, placement_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(idx);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      placements_due.push_back(fixed ? want : place_task(idx));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (placements_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TOTAL_TASKS:     cfg_total  = data[15:0];
         CSR_NODE_COUNT:      cfg_nodes  = data[8:0];
         CSR_CONTIGUOUS_MODE: cfg_contig = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [CSR_W-1:0] total_raw, logic [CSR_W-1:0] nodes_raw,
                            logic [CSR_W-1:0] mode_raw);
      write_csr(CSR_TOTAL_TASKS, total_raw);
      write_csr(CSR_NODE_COUNT, nodes_raw);
      write_csr(CSR_CONTIGUOUS_MODE, mode_raw);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      placement_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.worker_number     = rsp_tdata[WORKER_BITS-1:0];
         got.local_index       = rsp_tdata[WORKER_BITS +: TB_TASK_BITS];
         got.worker_task_count = rsp_tdata[WORKER_BITS + TB_TASK_BITS +: TB_TASK_BITS];
         got.invalid           = rsp_tuser;
         if (placements_due.size() == 0) begin
            report_mismatch("unexpected transaction, worker", 64'(got.worker_number), 64'd0);
         end else begin
            want = placements_due.pop_front();
            if (got.worker_number !== want.worker_number)
               report_mismatch("worker_number", 64'(got.worker_number),
                               64'(want.worker_number));
            if (got.local_index !== want.local_index)
               report_mismatch("local_index", 64'(got.local_index), 64'(want.local_index));
            if (got.worker_task_count !== want.worker_task_count)
               report_mismatch("worker_task_count", 64'(got.worker_task_count),
                               64'(want.worker_task_count));
            if (got.invalid !== want.invalid)
               report_mismatch("invalid", 64'(got.invalid), 64'(want.invalid));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("task_to_worker_mapper_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      placement_type bad, p;
      logic [CSR_W-1:0] last_total, last_nodes, last_mode;
      logic [CSR_W-1:0] t_raw, n_raw, m_raw;
      int unsigned total;
      logic [TB_TASK_BITS-1:0] idx;

      bad = '0;
      bad.invalid = 1'b1;

      // after reset, extremes, no workers, out of range
      add_row(0, 2, 0, 16'd0, 1, bad);
      add_row(0, 2, 0, 16'hFFFF, 1, bad);
      p = '{worker_number: 1, local_index: 0, worker_task_count: 1, invalid: 0};
      add_row(1, 2, 0, 16'd0, 1, p);
      add_row(1, 2, 0, 16'd1, 1, bad);
      add_row(1, 2, 1, 16'd0, 1, p);
      add_row(16'hFFFF, 256, 0, 16'd0, 0, bad);
      add_row(16'hFFFF, 256, 0, 16'hFFFE, 0, bad);
      add_row(16'hFFFF, 256, 0, 16'hFFFF, 1, bad);
      add_row(16'hFFFF, 256, 1, 16'd0, 0, bad);
      add_row(16'hFFFF, 256, 1, 16'hFFFE, 0, bad);
      add_row(16'hFFFF, 256, 1, 16'hFFFF, 1, bad);
      add_row(10, 0, 0, 16'd0, 1, bad);
      add_row(10, 1, 1, 16'd0, 1, bad);
      add_row(1000, 511, 0, 16'd999, 0, bad);
      add_row(300, 257, 1, 16'd299, 0, bad);
      add_row(5, 10, 0, 16'd4, 0, bad);
      add_row(10, 4, 1, 16'd0, 0, bad);
      add_row(10, 4, 1, 16'd3, 0, bad);
      add_row(10, 4, 1, 16'd4, 0, bad);
      add_row(10, 4, 1, 16'd6, 0, bad);
      add_row(10, 4, 1, 16'd9, 0, bad);
      add_row(10, 4, 0, 16'd9, 0, bad);
      // upper data bits above each register's width are dropped
      add_row(16'hAAAA, 16'hFE03, 16'hFFFE, 16'h5555, 0, bad);
      add_row(16'h5555, 16'h01FC, 16'h0001, 16'h2AAA, 0, bad);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      last_total = 0;
      last_nodes = 2;
      last_mode  = 0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].total_raw != last_total || directed_rows[i].nodes_raw != last_nodes
             || directed_rows[i].mode_raw != last_mode) begin
            drain();
            configure(directed_rows[i].total_raw, directed_rows[i].nodes_raw,
                      directed_rows[i].mode_raw);
            last_total = directed_rows[i].total_raw;
            last_nodes = directed_rows[i].nodes_raw;
            last_mode  = directed_rows[i].mode_raw;
         end
         send_task(directed_rows[i].task_idx, directed_rows[i].fixed, directed_rows[i].want);
      end

      // write to an unused index must leave the registers alone
      drain();
      write_csr(CSR_UNUSED, '1);
      @(negedge clock);
      csr_valid <= 1'b0;
      send_task(16'd0, 0, bad);
      send_task(16'h5554, 0, bad);

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 60; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 60; end
            default: begin send_gap_pct = 15; recv_stall_pct = 15; end
         endcase
         case (ph)
            0: begin t_raw = 16'hFFFF; n_raw = 256; m_raw = 1; end
            1: begin t_raw = 16'hFFFF; n_raw = 16'hFFFF; m_raw = 16'hFFFE; end
            2: begin t_raw = 1; n_raw = 2; m_raw = 0; end
            3: begin t_raw = 0; n_raw = 100; m_raw = 1; end
            default: begin
               case ($urandom_range(0, 3))
                  0: t_raw = CSR_W'($urandom_range(1, 40));
                  1: t_raw = CSR_W'($urandom_range(1, 600));
                  default: t_raw = CSR_W'($urandom);
               endcase
               case ($urandom_range(0, 9))
                  0: n_raw = CSR_W'($urandom_range(0, 1));
                  1: n_raw = CSR_W'($urandom_range(257, 511));
                  2: n_raw = CSR_W'($urandom_range(2, 12));
                  default: n_raw = CSR_W'($urandom_range(2, 256));
               endcase
               n_raw[CSR_W-1:9] = (CSR_W-9)'($urandom);
               m_raw = CSR_W'($urandom);
            end
         endcase
         drain();
         configure(t_raw, n_raw, m_raw);
         total = 32'(cfg_total);
         for (int k = 0; k < 46; k++) begin
            if (k == 20) drain();
            if (total != 0 && $urandom_range(0, 99) < 85) begin
               idx = TB_TASK_BITS'($urandom_range(0, total - 1));
            end else if ($urandom_range(0, 3) == 0) begin
               idx = TB_TASK_BITS'(total);
            end else begin
               idx = TB_TASK_BITS'($urandom);
            end
            send_task(idx, 0, bad);
         end
      end

      drain();
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (error_count == 0 && placements_due.size() == 0) begin
         $display("task_to_worker_mapper_unit regression: pass");
      end else begin
         $display("task_to_worker_mapper_unit regression: fail");
      end
      $finish;
   end

endmodule
